@@ hdl/tempo_synced_loop_phase_defines.svh @@
// Assertion macros for the loop phase clock.
// Included by the top level; compiles to nothing when SYNTH is defined.
`ifndef TEMPO_SYNCED_LOOP_PHASE_DEFINES_SVH
`define TEMPO_SYNCED_LOOP_PHASE_DEFINES_SVH
`ifndef SYNTH
`define TSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsl: assertion failed");
`define TSL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsl: assertion failed");
`else
`define TSL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TSL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/tsl_pkg.sv @@
// Shared widths, reset values and control types of the loop phase clock.
// No dependencies; used by every module of the block.
`default_nettype none
package tsl_pkg;
   localparam int PHASE_BITS_DEF = 24;
   localparam int RATE_W = 20;
   localparam int BEATS_W = 24;
   localparam int TEMPO_W = 26;
   localparam int POS_W = 48;
   localparam int SMP_W = 64;
   localparam int OUT_PH_W = 24;
   localparam int DIV_W = 50;
   localparam int B60_W = 30;
   localparam int CNT_W = 6;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [RATE_W-1:0] RATE_RST = 20'd48000;
   localparam logic [BEATS_W-1:0] BEATS_RST = 24'd262144;
   localparam logic [TEMPO_W-1:0] TEMPO_RST = 26'd7864320;
   localparam logic [TEMPO_W-1:0] TEMPO_MIN = 26'd65536;

   localparam logic REG_RATE = 1'b0;
   localparam logic REG_BEATS = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLR,
      OP_SHIFT,
      OP_ADD,
      OP_CAPT,
      OP_NEG
   } rem_op_type;

   typedef struct packed {
      rem_op_type op;
      logic       bit_in;
   } rem_ctl_type;
endpackage
`default_nettype wire

@@ hdl/tsl_dmul.sv @@
// Bit-serial multiplier forming the cycle divisor loop_beats * sample_rate * 60.
// Depends on tsl_pkg.
`default_nettype none
module tsl_dmul
   import tsl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [BEATS_W-1:0] beats,
   input  wire logic [RATE_W-1:0]  rate,
   output logic                    busy,
   output logic [DIV_W-1:0]        prod
);
   localparam int MC_W = $clog2(RATE_W);

   logic [B60_W-1:0]  b60_ff, b60_in;
   logic [RATE_W-1:0] rsh_ff, rsh_in;
   logic [DIV_W-1:0]  acc_ff, acc_in;
   logic [MC_W-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   always_comb begin
      b60_in = b60_ff;
      rsh_in = rsh_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         b60_in = {beats, 6'b000000} - {4'b0000, beats, 2'b00};
         rsh_in = (rate == '0) ? RATE_W'(1) : rate;
         acc_in = '0;
         cnt_in = MC_W'(RATE_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[DIV_W-2:0], 1'b0} + (rsh_ff[RATE_W-1] ? DIV_W'(b60_ff) : '0);
         rsh_in = {rsh_ff[RATE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      b60_ff <= b60_in;
      rsh_ff <= rsh_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

@@ hdl/tsl_rem.sv @@
// Shared remainder unit: one restoring step, doubling or modular add per cycle.
// Depends on tsl_pkg for widths and the step control struct.
`default_nettype none
module tsl_rem
   import tsl_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire rem_ctl_type      ctl,
   input  wire logic [DIV_W-1:0] div,
   output logic [DIV_W-1:0]      rem,
   output logic [PHASE_BITS-1:0] quo
);
   localparam int T_W = DIV_W + 2;

   logic [DIV_W-1:0]      r_ff, r_in;
   logic [DIV_W-1:0]      a_ff, a_in;
   logic [T_W-1:0]        amd_ff, amd_in;
   logic [PHASE_BITS-1:0] q_ff, q_in;
   logic [T_W-1:0]        t_sh, u_sh, t_add, u_add;

   always_comb begin
      t_sh = {1'b0, r_ff, ctl.bit_in};
      u_sh = t_sh - {2'b00, div};
      t_add = {2'b00, r_ff} + {2'b00, a_ff};
      u_add = {2'b00, r_ff} + amd_ff;
      r_in = r_ff;
      a_in = a_ff;
      amd_in = amd_ff;
      q_in = q_ff;
      case (ctl.op)
         OP_HOLD: begin
         end
         OP_CLR: begin
            r_in = '0;
            q_in = '0;
         end
         OP_SHIFT: begin
            r_in = u_sh[T_W-1] ? t_sh[DIV_W-1:0] : u_sh[DIV_W-1:0];
            q_in = {q_ff[PHASE_BITS-2:0], ~u_sh[T_W-1]};
         end
         OP_ADD: begin
            r_in = u_add[T_W-1] ? t_add[DIV_W-1:0] : u_add[DIV_W-1:0];
         end
         OP_CAPT: begin
            a_in = r_ff;
            amd_in = {2'b00, r_ff} - {2'b00, div};
            r_in = '0;
         end
         OP_NEG: begin
            if (r_ff != '0) begin
               r_in = div - r_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      a_ff <= a_in;
      amd_ff <= amd_in;
      q_ff <= q_in;
   end

   assign rem = r_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

@@ hdl/tempo_synced_loop_phase.sv @@
// Top level of the loop phase clock: handshake, state, sequencer, register port.
// Depends on tsl_pkg, tsl_dmul, tsl_rem and tempo_synced_loop_phase_defines.svh.
//
// One item per audio block, taken one at a time. A stopped block, or one that
// re-anchors without using a song position, goes straight to the result. A
// start with a valid position and unchanged tempo runs the shared remainder unit
// bit-serially over the 48 position bits, then over the PHASE_BITS fraction bits.
// Any other playing block takes the elapsed samples modulo the cycle divisor
// over 64 bits, a doubling and a conditional add per tempo bit for the tempo
// product, then the fraction bits; a divisor below the tempo keeps the anchor
// phase. The next beat is taken at the earliest in the cycle after the result
// is loaded. The divisor loop_beats * sample_rate * 60 is formed by a serial
// multiplier after reset and after each register write; req_ready stays low
// while it is started and runs. The result waits in an output register, so the
// next item is taken while it is still held; a second finished result waits in
// the sequencer and stalls the input until the first has gone.
`default_nettype none
`include "tempo_synced_loop_phase_defines.svh"
module tempo_synced_loop_phase
   import tsl_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_play_known,
   input  wire logic                     req_host_playing,
   input  wire logic                     req_tempo_valid,
   input  wire logic [TEMPO_W-1:0]       req_host_tempo,
   input  wire logic                     req_position_valid,
   input  wire logic signed [POS_W-1:0]  req_host_position,
   input  wire logic signed [SMP_W-1:0]  req_block_end,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [OUT_PH_W-1:0]           rsp_phase,
   output logic                          rsp_phase_reliable,
   output logic [TEMPO_W-1:0]            rsp_tempo_used,
   output logic                          rsp_reset_suggested,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [ADDR_W-1:0]        csr_paddr,
   input  wire logic [DATA_W-1:0]        csr_pwdata,
   output logic [DATA_W-1:0]             csr_prdata,
   output logic                          csr_pready
);
   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_ELAP   = 12'b000000000010,
      ST_EMOD   = 12'b000000000100,
      ST_CAPT   = 12'b000000001000,
      ST_MSH    = 12'b000000010000,
      ST_MADD   = 12'b000000100000,
      ST_POSABS = 12'b000001000000,
      ST_POSMOD = 12'b000010000000,
      ST_POSNEG = 12'b000100000000,
      ST_FRAC   = 12'b001000000000,
      ST_UPD    = 12'b010000000000,
      ST_FIN    = 12'b100000000000
   } seq_state_type;

   seq_state_type         st_ff, st_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [RATE_W-1:0]     rate_ff, rate_in;
   logic [BEATS_W-1:0]    beats_ff, beats_in;
   logic                  dstart_ff, dstart_in;
   logic [TEMPO_W-1:0]    held_tempo_ff, held_tempo_in;
   logic                  was_playing_ff, was_playing_in;
   logic                  started_ff, started_in;
   logic [SMP_W-1:0]      anchor_sample_ff, anchor_sample_in;
   logic [PHASE_BITS-1:0] anchor_phase_ff, anchor_phase_in;
   logic [PHASE_BITS-1:0] last_phase_ff, last_phase_in;
   logic [SMP_W-1:0]      sh_ff, sh_in;
   logic [TEMPO_W-1:0]    tsh_ff, tsh_in;
   logic                  pos_mode_ff, pos_mode_in;
   logic                  neg_ff, neg_in;
   logic                  reset_sug_ff, reset_sug_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_PH_W-1:0]   rsp_phase_ff, rsp_phase_in;
   logic                  rsp_rel_ff, rsp_rel_in;
   logic [TEMPO_W-1:0]    rsp_tempo_ff, rsp_tempo_in;
   logic                  rsp_reset_ff, rsp_reset_in;

   logic                  csr_wr;
   logic [BEATS_W-1:0]    beats_eff;
   logic                  dm_busy;
   logic [DIV_W-1:0]      dm_prod;
   logic [DIV_W-1:0]      div;
   logic [DIV_W-1:0]      rem;
   logic [PHASE_BITS-1:0] quo;
   rem_ctl_type           ctl;

   logic                  playing, just_started, changed, reanchor, use_pos;
   logic [TEMPO_W-1:0]    tempo_clamp, tempo_new;
   logic [PHASE_BITS-1:0] ph_keep;
   logic [SMP_W-1:0]      elapsed;
   logic [POS_W-1:0]      pos_mag;
   logic [OUT_PH_W-1:0]   ph_view;
   logic                  rem_live;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_BEATS) ? DATA_W'(beats_ff) : DATA_W'(rate_ff);

   always_comb begin
      rate_in = rate_ff;
      beats_in = beats_ff;
      dstart_in = csr_wr;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_BEATS) begin
            beats_in = csr_pwdata[BEATS_W-1:0];
         end else begin
            rate_in = csr_pwdata[RATE_W-1:0];
         end
      end
   end

   assign beats_eff = (beats_ff == '0) ? BEATS_W'(1) : beats_ff;
   assign div = pos_mode_ff ? DIV_W'(beats_eff) : dm_prod;

   tsl_dmul u_dmul (
      .clock (clock),
      .reset (reset),
      .start (dstart_ff),
      .beats (beats_eff),
      .rate  (rate_ff),
      .busy  (dm_busy),
      .prod  (dm_prod)
   );

   tsl_rem #(
      .PHASE_BITS (PHASE_BITS)
   ) u_rem (
      .clock (clock),
      .ctl   (ctl),
      .div   (div),
      .rem   (rem),
      .quo   (quo)
   );

   generate
      if (PHASE_BITS >= OUT_PH_W) begin : g_trunc
         assign ph_view = last_phase_ff[PHASE_BITS-1 -: OUT_PH_W];
      end else begin : g_pad
         assign ph_view = {last_phase_ff, {(OUT_PH_W - PHASE_BITS){1'b0}}};
      end
   endgenerate

   // beat decode
   assign playing = req_play_known ? req_host_playing : 1'b1;
   assign tempo_clamp = (req_host_tempo < TEMPO_MIN) ? TEMPO_MIN : req_host_tempo;
   assign tempo_new = req_tempo_valid ? tempo_clamp : held_tempo_ff;
   assign just_started = playing & ~was_playing_ff;
   assign changed = tempo_new != held_tempo_ff;
   assign reanchor = ~started_ff | just_started | changed;
   assign use_pos = reanchor & ~changed & just_started & req_position_valid;
   assign ph_keep = changed ? '0 : last_phase_ff;

   assign elapsed = ($signed(sh_ff) > $signed(anchor_sample_ff)) ? sh_ff - anchor_sample_ff : '0;
   assign pos_mag = neg_ff ? -sh_ff[POS_W-1:0] : sh_ff[POS_W-1:0];

   assign req_ready = (st_ff == ST_IDLE) & ~dstart_ff & ~dm_busy;

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      held_tempo_in = held_tempo_ff;
      was_playing_in = was_playing_ff;
      started_in = started_ff;
      anchor_sample_in = anchor_sample_ff;
      anchor_phase_in = anchor_phase_ff;
      last_phase_in = last_phase_ff;
      sh_in = sh_ff;
      tsh_in = tsh_ff;
      pos_mode_in = pos_mode_ff;
      neg_in = neg_ff;
      reset_sug_in = reset_sug_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_rel_in = rsp_rel_ff;
      rsp_tempo_in = rsp_tempo_ff;
      rsp_reset_in = rsp_reset_ff;
      ctl.op = OP_HOLD;
      ctl.bit_in = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               was_playing_in = playing;
               reset_sug_in = reanchor;
               if (reanchor) begin
                  started_in = 1'b1;
                  held_tempo_in = tempo_new;
               end
               if (!playing || (reanchor && !use_pos)) begin
                  anchor_sample_in = req_block_end;
                  anchor_phase_in = ph_keep;
                  last_phase_in = ph_keep;
                  st_in = ST_FIN;
               end else if (use_pos) begin
                  anchor_sample_in = req_block_end;
                  sh_in = {{(SMP_W - POS_W){1'b0}}, req_host_position};
                  neg_in = req_host_position[POS_W-1];
                  pos_mode_in = 1'b1;
                  st_in = ST_POSABS;
               end else begin
                  sh_in = req_block_end;
                  pos_mode_in = 1'b0;
                  st_in = ST_ELAP;
               end
            end
         end
         ST_ELAP: begin
            ctl.op = OP_CLR;
            sh_in = elapsed;
            if (dm_prod < DIV_W'(held_tempo_ff)) begin
               last_phase_in = anchor_phase_ff;
               st_in = ST_FIN;
            end else begin
               cnt_in = CNT_W'(SMP_W - 1);
               st_in = ST_EMOD;
            end
         end
         ST_EMOD: begin
            ctl.op = OP_SHIFT;
            ctl.bit_in = sh_ff[SMP_W-1];
            sh_in = {sh_ff[SMP_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_CAPT;
            end
         end
         ST_CAPT: begin
            ctl.op = OP_CAPT;
            tsh_in = held_tempo_ff;
            cnt_in = CNT_W'(TEMPO_W - 1);
            st_in = ST_MSH;
         end
         ST_MSH: begin
            ctl.op = OP_SHIFT;
            st_in = ST_MADD;
         end
         ST_MADD: begin
            ctl.op = tsh_ff[TEMPO_W-1] ? OP_ADD : OP_HOLD;
            tsh_in = {tsh_ff[TEMPO_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in = CNT_W'(PHASE_BITS - 1);
               st_in = ST_FRAC;
            end else begin
               st_in = ST_MSH;
            end
         end
         ST_POSABS: begin
            ctl.op = OP_CLR;
            sh_in = {pos_mag, {(SMP_W - POS_W){1'b0}}};
            cnt_in = CNT_W'(POS_W - 1);
            st_in = ST_POSMOD;
         end
         ST_POSMOD: begin
            ctl.op = OP_SHIFT;
            ctl.bit_in = sh_ff[SMP_W-1];
            sh_in = {sh_ff[SMP_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_POSNEG;
            end
         end
         ST_POSNEG: begin
            ctl.op = neg_ff ? OP_NEG : OP_HOLD;
            cnt_in = CNT_W'(PHASE_BITS - 1);
            st_in = ST_FRAC;
         end
         ST_FRAC: begin
            ctl.op = OP_SHIFT;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (pos_mode_ff) begin
               anchor_phase_in = quo;
               last_phase_in = quo;
            end else begin
               last_phase_in = anchor_phase_ff + quo;
            end
            st_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = ph_view;
               rsp_rel_in = started_ff;
               rsp_tempo_in = held_tempo_ff;
               rsp_reset_in = reset_sug_ff;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
         rate_ff <= RATE_RST;
         beats_ff <= BEATS_RST;
         dstart_ff <= 1'b1;
         held_tempo_ff <= TEMPO_RST;
         was_playing_ff <= 1'b0;
         started_ff <= 1'b0;
         anchor_sample_ff <= '0;
         anchor_phase_ff <= '0;
         last_phase_ff <= '0;
         pos_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         rate_ff <= rate_in;
         beats_ff <= beats_in;
         dstart_ff <= dstart_in;
         held_tempo_ff <= held_tempo_in;
         was_playing_ff <= was_playing_in;
         started_ff <= started_in;
         anchor_sample_ff <= anchor_sample_in;
         anchor_phase_ff <= anchor_phase_in;
         last_phase_ff <= last_phase_in;
         pos_mode_ff <= pos_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sh_ff <= sh_in;
      tsh_ff <= tsh_in;
      neg_ff <= neg_in;
      reset_sug_ff <= reset_sug_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_rel_ff <= rsp_rel_in;
      rsp_tempo_ff <= rsp_tempo_in;
      rsp_reset_ff <= rsp_reset_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;
   assign rsp_phase_reliable = rsp_rel_ff;
   assign rsp_tempo_used = rsp_tempo_ff;
   assign rsp_reset_suggested = rsp_reset_ff;

   assign rem_live = (st_ff == ST_EMOD) | (st_ff == ST_MSH) | (st_ff == ST_MADD) |
                     (st_ff == ST_POSMOD) | (st_ff == ST_FRAC);

   `TSL_ASSERT_NXT(a_leave_idle, clock, reset, req_valid && req_ready, st_ff != ST_IDLE)
   `TSL_ASSERT_IMP(a_rem_below_div, clock, reset, rem_live, rem < div)
   `TSL_ASSERT_IMP(a_rsp_sane, clock, reset, rsp_valid, rsp_phase_reliable && rsp_tempo_used >= TEMPO_MIN)
endmodule
`default_nettype wire

@@ bench/tb_tempo_synced_loop_phase.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tempo_synced_loop_phase: audio block reports in, loop phase beats out.
// Predicts each beat with its own tempo/anchor clock and compares it field by field.
// Depends on tsl_pkg and the tempo_synced_loop_phase top level.
module tb_tempo_synced_loop_phase
   import tsl_pkg::*;
;

   localparam int STALL_CYCLES = 600;

   typedef struct {
      logic                    known;
      logic                    playing;
      logic                    tempo_ok;
      logic [TEMPO_W-1:0]      tempo;
      logic                    pos_ok;
      logic signed [POS_W-1:0] pos;
      logic signed [SMP_W-1:0] blk_end;
   } audio_block_type;

   typedef struct {
      logic [OUT_PH_W-1:0] phase;
      logic                reliable;
      logic [TEMPO_W-1:0]  tempo;
      logic                resync;
   } phase_result_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_play_known;
   logic req_host_playing;
   logic req_tempo_valid;
   logic [TEMPO_W-1:0] req_host_tempo;
   logic req_position_valid;
   logic signed [POS_W-1:0] req_host_position;
   logic signed [SMP_W-1:0] req_block_end;
   logic rsp_valid;
   logic rsp_ready;
   logic [OUT_PH_W-1:0] rsp_phase;
   logic rsp_phase_reliable;
   logic [TEMPO_W-1:0] rsp_tempo_used;
   logic rsp_reset_suggested;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // loop clock shadow
   logic [RATE_W-1:0] cfg_rate = RATE_RST;
   logic [BEATS_W-1:0] cfg_beats = BEATS_RST;
   logic [TEMPO_W-1:0] held_tempo = TEMPO_RST;
   logic was_playing = 1'b0;
   logic started = 1'b0;
   logic signed [SMP_W-1:0] anchor_sample = '0;
   logic [OUT_PH_W-1:0] anchor_phase = '0;
   logic [OUT_PH_W-1:0] last_phase = '0;

   phase_result_type expected_phases[$];
   phase_result_type oldest_phase;
   int mismatch_count = 0;
   bit idling = 1'b1;
   bit hold_rsp = 1'b0;

   tempo_synced_loop_phase DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_play_known(req_play_known),
      .req_host_playing(req_host_playing),
      .req_tempo_valid(req_tempo_valid),
      .req_host_tempo(req_host_tempo),
      .req_position_valid(req_position_valid),
      .req_host_position(req_host_position),
      .req_block_end(req_block_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_phase(rsp_phase),
      .rsp_phase_reliable(rsp_phase_reliable),
      .rsp_tempo_used(rsp_tempo_used),
      .rsp_reset_suggested(rsp_reset_suggested),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   initial begin
      #40_000_000;
      $display("tb_tempo_synced_loop_phase: errors");
      $finish;
   end

   function automatic phase_result_type predict_phase(input audio_block_type b);
      logic [63:0] rate;
      logic [63:0] beats;
      logic [TEMPO_W-1:0] tempo;
      logic playing;
      logic starting;
      logic tempo_moved;
      logic [127:0] d;
      logic [127:0] rem;
      logic [127:0] inc;
      logic [63:0] elapsed;
      longint pos_l;
      longint m;
      phase_result_type res;
      rate = (cfg_rate == 0) ? 64'd1 : 64'(cfg_rate);
      beats = (cfg_beats == 0) ? 64'd1 : 64'(cfg_beats);
      playing = b.known ? b.playing : 1'b1;
      tempo = held_tempo;
      if (b.tempo_ok) begin
         tempo = (b.tempo < TEMPO_MIN) ? TEMPO_MIN : b.tempo;
      end
      starting = playing && !was_playing;
      tempo_moved = (tempo != held_tempo);
      res.resync = 1'b0;
      if (!started || starting || tempo_moved) begin
         started = 1'b1;
         held_tempo = tempo;
         anchor_sample = b.blk_end;
         if (tempo_moved) begin
            anchor_phase = '0;
         end else if (starting && b.pos_ok) begin
            pos_l = b.pos;
            m = pos_l % longint'(beats);
            if (m < 0) begin
               m = m + longint'(beats);
            end
            anchor_phase = OUT_PH_W'((128'(m) << OUT_PH_W) / 128'(beats));
         end else begin
            anchor_phase = last_phase;
         end
         last_phase = anchor_phase;
         res.resync = 1'b1;
      end
      if (!playing) begin
         anchor_sample = b.blk_end;
         anchor_phase = last_phase;
      end else begin
         d = 128'(beats) * 128'(rate) * 128'(60);
         elapsed = (b.blk_end > anchor_sample) ? 64'(b.blk_end - anchor_sample) : 64'd0;
         inc = '0;
         // a cycle shorter than one sample advances by whole cycles only
         if (d >= 128'(held_tempo)) begin
            rem = ((128'(elapsed) % d) * 128'(held_tempo)) % d;
            inc = (rem << OUT_PH_W) / d;
         end
         last_phase = anchor_phase + inc[OUT_PH_W-1:0];
      end
      was_playing = playing;
      res.phase = last_phase;
      res.reliable = started;
      res.tempo = held_tempo;
      return res;
   endfunction

   function automatic audio_block_type report(input logic known, input logic playing,
                                              input logic tempo_ok,
                                              input logic [TEMPO_W-1:0] tempo,
                                              input logic pos_ok, input logic [POS_W-1:0] pos,
                                              input logic [SMP_W-1:0] blk_end);
      audio_block_type b;
      b.known = known;
      b.playing = playing;
      b.tempo_ok = tempo_ok;
      b.tempo = tempo;
      b.pos_ok = pos_ok;
      b.pos = pos;
      b.blk_end = blk_end;
      return b;
   endfunction

   task automatic send_block(input audio_block_type b);
      int gap;
      gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_play_known <= b.known;
      req_host_playing <= b.playing;
      req_tempo_valid <= b.tempo_ok;
      req_host_tempo <= b.tempo;
      req_position_valid <= b.pos_ok;
      req_host_position <= b.pos;
      req_block_end <= b.blk_end;
      do @(posedge clock); while (!req_ready);
      expected_phases.push_back(predict_phase(b));
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_phases.size() != 0);
   endtask

   task automatic csr_write(input logic which, input logic [DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      if (which == REG_RATE) begin
         cfg_rate = value[RATE_W-1:0];
      end else begin
         cfg_beats = value[BEATS_W-1:0];
      end
   endtask

   task automatic set_loop_format(input logic [DATA_W-1:0] rate, input logic [DATA_W-1:0] beats);
      settle_pipeline();
      csr_write(REG_RATE, rate);
      csr_write(REG_BEATS, beats);
   endtask

   function automatic logic [TEMPO_W-1:0] random_tempo();
      if ($urandom_range(0, 5) == 0) begin
         return TEMPO_W'($urandom);
      end
      return TEMPO_W'($urandom_range(40 << 16, 300 << 16));
   endfunction

   task automatic test_directed_reports();
      send_block(report(1, 0, 0, 0, 0, 0, 64'd1000));
      send_block(report(1, 0, 1, 26'd0, 0, 0, 64'd2000));
      send_block(report(1, 1, 1, 26'd65536, 1, 48'h7FFF_FFFF_FFFF, 64'd3000));
      send_block(report(1, 1, 1, 26'd65536, 1, 0, 64'd51000));
      send_block(report(1, 1, 1, 26'h3FF_FFFF, 1, 0, 64'd99000));
      send_block(report(1, 1, 0, 0, 0, 0, 64'd500));
      send_block(report(1, 0, 0, 0, 0, 0, 64'd600));
      send_block(report(1, 1, 1, 26'd7864320, 1, 48'h8000_0000_0000, 64'd700));
      send_block(report(1, 1, 1, 26'd7864320, 1, 0, 64'd48700));
      send_block(report(1, 0, 1, 26'd7864320, 0, 0, 64'd50000));
      send_block(report(1, 1, 1, 26'd7864320, 0, 0, 64'd50000));
      send_block(report(0, 0, 0, 0, 1, 48'h0000_0001_0000, 64'd74000));
      send_block(report(1, 1, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
      send_block(report(1, 1, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
      send_block(report(1, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
      send_block(report(1, 1, 1, 26'd7864320, 1, 48'hFFFF_FFFF_FFFF, 64'h8000_0000_0000_0100));
      send_block(report(1, 1, 0, 0, 0, 0, 64'h8000_0000_0000_2000));
      send_block(report(1, 1, 1, 26'd65535, 1, 0, 64'h8000_0000_0000_3000));
      send_block(report(1, 1, 1, 26'd65535, 1, 0, 64'h8000_0000_0000_9000));
   endtask

   task automatic test_register_extremes();
      logic [DATA_W-1:0] rates[5] = '{32'd1, 32'd0, 32'd768000, 32'hFFFF_FFFF, 32'd48000};
      logic [DATA_W-1:0] beats[5] = '{32'd1, 32'd0, 32'd16777215, 32'hFFFF_FFFF, 32'd262144};
      for (int i = 0; i < 5; i++) begin
         set_loop_format(rates[i], beats[i]);
         send_block(report(1, 0, 1, 26'd7864320, 0, 0, 64'd100));
         send_block(report(1, 1, 1, 26'd7864320, 1, 48'h0000_0003_8000, 64'd200));
         send_block(report(1, 1, 1, 26'd7864320, 0, 0, 64'd48237));
         send_block(report(1, 1, 1, 26'd9000000, 0, 0, 64'd1000000));
         send_block(report(1, 1, 0, 0, 0, 0, 64'd1000000007));
      end
   endtask

   task automatic test_result_backpressure();
      logic signed [SMP_W-1:0] blk_end;
      blk_end = 64'd5000;
      hold_rsp = 1'b1;
      for (int i = 0; i < 14; i++) begin
         blk_end = blk_end + $urandom_range(64, 2048);
         send_block(report(1, 1, 1, 26'd7864320, 1, 0, blk_end));
      end
      settle_pipeline();
   endtask

   task automatic run_sessions(input int count);
      audio_block_type b;
      logic signed [SMP_W-1:0] blk_end;
      logic signed [POS_W-1:0] pos;
      logic [TEMPO_W-1:0] tempo;
      logic playing;
      int sent;
      int len;
      int step;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 2) == 0) begin
            set_loop_format(($urandom_range(0, 2) == 0) ? $urandom_range(1, 64)
                                                       : $urandom_range(1, 768000),
                            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1024)
                                                       : $urandom_range(1, 24'hFF_FFFF));
         end
         case ($urandom_range(0, 2))
            0: blk_end = SMP_W'($urandom_range(0, 100000));
            1: blk_end = SMP_W'({$urandom, $urandom});
            default: blk_end = 64'h7FFF_FFFF_FFFF_0000;
         endcase
         pos = ($urandom_range(0, 3) == 0) ? POS_W'({$urandom, $urandom})
                                          : POS_W'($urandom_range(0, 1 << 24));
         tempo = random_tempo();
         playing = 1'($urandom_range(0, 1));
         len = $urandom_range(10, 80);
         for (int i = 0; i < len && sent < count; i++) begin
            step = ($urandom_range(0, 9) == 0) ? int'($urandom) : $urandom_range(16, 4096);
            blk_end = blk_end + step;
            pos = pos + POS_W'($urandom_range(0, 1 << 16));
            if ($urandom_range(0, 19) == 0) begin
               playing = !playing;
            end
            if ($urandom_range(0, 29) == 0) begin
               tempo = random_tempo();
            end
            b = report($urandom_range(0, 15) != 0, playing, $urandom_range(0, 7) != 0, tempo,
                       $urandom_range(0, 3) != 0, pos, blk_end);
            send_block(b);
            sent++;
         end
      end
      settle_pipeline();
   endtask

   task automatic test_random_sessions(input int count);
      run_sessions(count);
   endtask

   task automatic test_noise_reports(input int count);
      for (int i = 0; i < count; i++) begin
         send_block(report(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), TEMPO_W'($urandom),
                           1'($urandom_range(0, 1)), POS_W'({$urandom, $urandom}),
                           SMP_W'({$urandom, $urandom})));
      end
      settle_pipeline();
   endtask

   task automatic test_quiet_tail(input int count);
      idling = 1'b0;
      set_loop_format(32'd48000, 32'd262144);
      run_sessions(count);
   endtask

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (idling && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_phases.size() == 0) begin
            $display("%0t unexpected beat: phase %h tempo %h", $time, rsp_phase, rsp_tempo_used);
            mismatch_count++;
         end else begin
            oldest_phase = expected_phases.pop_front();
            if (rsp_phase !== oldest_phase.phase) begin
               $display("%0t phase: expected %h, actual %h", $time, oldest_phase.phase,
                        rsp_phase);
               mismatch_count++;
            end
            if (rsp_phase_reliable !== oldest_phase.reliable) begin
               $display("%0t phase_reliable: expected %b, actual %b", $time,
                        oldest_phase.reliable, rsp_phase_reliable);
               mismatch_count++;
            end
            if (rsp_tempo_used !== oldest_phase.tempo) begin
               $display("%0t tempo_used: expected %h, actual %h", $time, oldest_phase.tempo,
                        rsp_tempo_used);
               mismatch_count++;
            end
            if (rsp_reset_suggested !== oldest_phase.resync) begin
               $display("%0t reset_suggested: expected %b, actual %b", $time,
                        oldest_phase.resync, rsp_reset_suggested);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_play_known <= 1'b0;
      req_host_playing <= 1'b0;
      req_tempo_valid <= 1'b0;
      req_host_tempo <= '0;
      req_position_valid <= 1'b0;
      req_host_position <= '0;
      req_block_end <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_reports();
      test_register_extremes();
      test_result_backpressure();
      test_random_sessions(1000);
      test_noise_reports(200);
      test_quiet_tail(150);
      settle_pipeline();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_phases.size() == 0) begin
         $display("tb_tempo_synced_loop_phase: clean");
      end else begin
         $display("tb_tempo_synced_loop_phase: errors");
      end
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/tsl_pkg.sv
hdl/tsl_dmul.sv
hdl/tsl_rem.sv
hdl/tempo_synced_loop_phase.sv
bench/tb_tempo_synced_loop_phase.sv
